// ===== design/icb_pkg.sv =====
// Shared types and constants for the interval cluster batcher.
`default_nettype none

package icb_pkg;

    localparam int unsigned TARGET_WIDTH = 16;
    localparam int unsigned LIMIT_WIDTH = 24;
    localparam logic [LIMIT_WIDTH-1:0] PART_LIMIT_RESET = 24'd20000;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_WIDTH = 2;
    localparam int unsigned QUEUE_CNT_WIDTH = 3;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } icb_push_t;

endpackage

`default_nettype wire

// ===== design/interval_cluster_batcher.sv =====
// Top level of the interval cluster batcher.
//
//  Channel   Signals                                        Beat moves when
//  in        in_valid, in_ready, record fields              in_valid && in_ready
//  out       out_valid, out_ready, cluster fields           out_valid && out_ready
//  config    cfg_we, cfg_wdata (part limit)                 cfg_we
//
// One record is taken every cycle while the four-entry queue has room for two entries.
// A closed cluster is written to the queue and then registered as the output beat.
// A final record closing a cluster yields two beats, gapless while out_ready is high.
// Reset clears all stream state and sets the part limit to 20000.
// Output stalls fill the queue, and in_ready falls once fewer than two slots are free.
`default_nettype none

module interval_cluster_batcher #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [icb_pkg::LIMIT_WIDTH-1:0]  cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [icb_pkg::TARGET_WIDTH-1:0] target_id,
    input  wire logic [COORD_WIDTH-1:0]           start_pos,
    input  wire logic [COORD_WIDTH-1:0]           end_pos,
    input  wire logic                             final_record,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [icb_pkg::TARGET_WIDTH-1:0]      cluster_target,
    output logic [COORD_WIDTH-1:0]                cluster_start,
    output logic [COORD_WIDTH-1:0]                cluster_end,
    output logic [COUNT_WIDTH-1:0]                cluster_count,
    output logic [COUNT_WIDTH-1:0]                batch_number,
    output logic                                  new_batch,
    output logic                                  last_of_run
);
    import icb_pkg::*;

    localparam int unsigned ENTRY_WIDTH = 2 + TARGET_WIDTH + 2 * COORD_WIDTH + COUNT_WIDTH;

    logic [LIMIT_WIDTH-1:0] limit_reg;
    icb_push_t              push;
    logic [ENTRY_WIDTH-1:0] entry_a, entry_b, head;
    logic                   room, pop, head_valid, accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= PART_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    assign in_ready = room;
    assign accept = in_valid && room;

    icb_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .target_id    (target_id),
        .start_pos    (start_pos),
        .end_pos      (end_pos),
        .final_record (final_record),
        .push         (push),
        .entry_a      (entry_a),
        .entry_b      (entry_b)
    );

    icb_queue #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .entry_a    (entry_a),
        .entry_b    (entry_b),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    icb_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .limit          (limit_reg),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cluster_target (cluster_target),
        .cluster_start  (cluster_start),
        .cluster_end    (cluster_end),
        .cluster_count  (cluster_count),
        .batch_number   (batch_number),
        .new_batch      (new_batch),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire

// ===== design/icb_front.sv =====
// Front part: takes records, grows the open cluster and hands closed clusters on.
`default_nettype none

module icb_front #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned ENTRY_WIDTH = 2 + 16 + 2 * COORD_WIDTH + COUNT_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic [icb_pkg::TARGET_WIDTH-1:0]    target_id,
    input  wire logic [COORD_WIDTH-1:0]              start_pos,
    input  wire logic [COORD_WIDTH-1:0]              end_pos,
    input  wire logic                                final_record,
    output icb_pkg::icb_push_t                       push,
    output logic [ENTRY_WIDTH-1:0]                   entry_a,
    output logic [ENTRY_WIDTH-1:0]                   entry_b
);
    import icb_pkg::*;

    logic                    open_reg, open_next;
    logic [TARGET_WIDTH-1:0] tgt_reg, tgt_next;
    logic [COORD_WIDTH-1:0]  min_reg, min_next;
    logic [COORD_WIDTH-1:0]  max_reg, max_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                    match;
    logic [TARGET_WIDTH-1:0] tgt_upd;
    logic [COORD_WIDTH-1:0]  min_upd, max_upd;
    logic [COUNT_WIDTH-1:0]  cnt_upd;

    assign match = open_reg && (target_id == tgt_reg) && (start_pos < max_reg)
                   && (end_pos > min_reg);

    always_comb
    begin
        if (match)
        begin
            tgt_upd = tgt_reg;
            min_upd = (start_pos < min_reg) ? start_pos : min_reg;
            max_upd = (end_pos > max_reg) ? end_pos : max_reg;
            cnt_upd = (cnt_reg != {COUNT_WIDTH{1'b1}}) ? cnt_reg + 1'b1 : cnt_reg;
        end
        else
        begin
            tgt_upd = target_id;
            min_upd = start_pos;
            max_upd = end_pos;
            cnt_upd = COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        open_next = open_reg;
        tgt_next  = tgt_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (final_record)
            begin
                open_next = 1'b0;
                tgt_next  = '0;
                min_next  = '0;
                max_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                open_next = 1'b1;
                tgt_next  = tgt_upd;
                min_next  = min_upd;
                max_next  = max_upd;
                cnt_next  = cnt_upd;
            end
        end
    end

    assign push.push_a = accept && open_reg && !match;
    assign push.push_b = accept && final_record;
    assign entry_a = {1'b0, !final_record, tgt_reg, min_reg, max_reg, cnt_reg};
    assign entry_b = {1'b1, 1'b1, tgt_upd, min_upd, max_upd, cnt_upd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            tgt_reg  <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            open_reg <= open_next;
            tgt_reg  <= tgt_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/icb_queue.sv =====
// Short queue between front and back that takes up to two entries a cycle.
`default_nettype none

module icb_queue #(
    parameter int unsigned ENTRY_WIDTH = 138
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire icb_pkg::icb_push_t     push,
    input  wire logic [ENTRY_WIDTH-1:0] entry_a,
    input  wire logic [ENTRY_WIDTH-1:0] entry_b,
    output logic                        room,
    input  wire logic                   pop,
    output logic                        head_valid,
    output logic [ENTRY_WIDTH-1:0]      head
);
    import icb_pkg::*;

    logic [ENTRY_WIDTH-1:0]     mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] wp_reg, wp_next;
    logic [QUEUE_PTR_WIDTH-1:0] rp_reg, rp_next;
    logic [QUEUE_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [QUEUE_CNT_WIDTH-1:0] n_push;
    logic [QUEUE_PTR_WIDTH-1:0] wp_plus;

    assign n_push = QUEUE_CNT_WIDTH'(push.push_a) + QUEUE_CNT_WIDTH'(push.push_b);
    assign wp_plus = wp_reg + 1'b1;
    assign room = (cnt_reg <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + n_push[QUEUE_PTR_WIDTH-1:0];
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + n_push - QUEUE_CNT_WIDTH'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
        begin
            mem[wp_reg] <= entry_a;
            if (push.push_b)
            begin
                mem[wp_plus] <= entry_b;
            end
        end
        else if (push.push_b)
        begin
            mem[wp_reg] <= entry_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/icb_back.sv =====
// Back part: places each closed cluster in a batch and holds the result beat.
`default_nettype none

module icb_back #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned ENTRY_WIDTH = 2 + 16 + 2 * COORD_WIDTH + COUNT_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [icb_pkg::LIMIT_WIDTH-1:0]  limit,
    input  wire logic                             head_valid,
    input  wire logic [ENTRY_WIDTH-1:0]           head,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [icb_pkg::TARGET_WIDTH-1:0]      cluster_target,
    output logic [COORD_WIDTH-1:0]                cluster_start,
    output logic [COORD_WIDTH-1:0]                cluster_end,
    output logic [COUNT_WIDTH-1:0]                cluster_count,
    output logic [COUNT_WIDTH-1:0]                batch_number,
    output logic                                  new_batch,
    output logic                                  last_of_run
);
    import icb_pkg::*;

    localparam int unsigned FILL_WIDTH = COUNT_WIDTH + 1;
    localparam int unsigned SUM_WIDTH = (COUNT_WIDTH + 2 > LIMIT_WIDTH + 1) ?
                                        COUNT_WIDTH + 2 : LIMIT_WIDTH + 1;

    logic                    h_end, h_last;
    logic [TARGET_WIDTH-1:0] h_tgt;
    logic [COORD_WIDTH-1:0]  h_min, h_max;
    logic [COUNT_WIDTH-1:0]  h_cnt;
    logic [FILL_WIDTH-1:0]   fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0]  idx_reg, idx_next;
    logic [SUM_WIDTH-1:0]    sum, sum_kept;
    logic                    split, opened;
    logic                    valid_reg, valid_next;

    assign {h_end, h_last, h_tgt, h_min, h_max, h_cnt} = head;
    assign pop = head_valid && (!valid_reg || out_ready);

    assign sum = SUM_WIDTH'(fill_reg) + SUM_WIDTH'(h_cnt);
    assign split = (fill_reg != '0) && (sum > SUM_WIDTH'(limit));
    assign opened = split || (fill_reg == '0);

    always_comb
    begin
        sum_kept = split ? SUM_WIDTH'(h_cnt) : sum;
        if (sum_kept > SUM_WIDTH'({FILL_WIDTH{1'b1}}))
        begin
            fill_next = {FILL_WIDTH{1'b1}};
        end
        else
        begin
            fill_next = sum_kept[FILL_WIDTH-1:0];
        end
        if (split && (idx_reg != {COUNT_WIDTH{1'b1}}))
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
        valid_next = pop || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cluster_target <= h_tgt;
            cluster_start  <= h_min;
            cluster_end    <= h_max;
            cluster_count  <= h_cnt;
            batch_number   <= idx_next;
            new_batch      <= opened;
            last_of_run    <= h_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                if (h_end)
                begin
                    fill_reg <= '0;
                    idx_reg  <= '0;
                end
                else
                begin
                    fill_reg <= fill_next;
                    idx_reg  <= idx_next;
                end
            end
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/icb_checker.sv =====
// Port-level checks for the interval cluster batcher, bound to the top level.
`default_nettype none

module icb_checker #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned COORD_WIDTH = 32
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [icb_pkg::TARGET_WIDTH-1:0] cluster_target,
    input wire logic [COORD_WIDTH-1:0]           cluster_start,
    input wire logic [COUNT_WIDTH-1:0]           cluster_count,
    input wire logic [COUNT_WIDTH-1:0]           batch_number,
    input wire logic                             last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cluster_target)
        && $stable(cluster_start) && $stable(cluster_count) && $stable(batch_number))
        else $error("Result beat changed while stalled.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cluster_count != '0)
        else $error("Closed cluster has no records.");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("Second beat of a pair did not follow at once.");

endmodule

bind interval_cluster_batcher icb_checker #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
) u_icb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cluster_target (cluster_target),
    .cluster_start  (cluster_start),
    .cluster_count  (cluster_count),
    .batch_number   (batch_number),
    .last_of_run    (last_of_run)
);

`default_nettype wire
